// ===== hdl/biu_pkg.sv =====
// biu_pkg: shared widths, register codes and reset values of the bilinear upscaler
// no dependencies; imported by biu_ram, bilinear_image_upscaler and its testbench
package biu_pkg;

  // payload field widths
  localparam int X_W   = 11;
  localparam int Y_W   = 11;
  localparam int CH_W  = 10;
  localparam int PIX_W = 3 * CH_W;
  localparam int OUT_W = 8;

  // stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  // configuration register fields
  localparam int SRC_W_FW   = 11;
  localparam int SRC_H_FW   = 10;
  localparam int DST_W_FW   = 12;
  localparam int DST_H_FW   = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_idx_t;

  // register values after reset
  localparam int SRC_W_RST = 1024;
  localparam int SRC_H_RST = 512;
  localparam int DST_W_RST = 2048;
  localparam int DST_H_RST = 2048;

  // default limits
  localparam int DEF_MAX_SRC_WIDTH  = 1024;
  localparam int DEF_MAX_SRC_HEIGHT = 512;
  localparam int DEF_MAX_DST_WIDTH  = 2048;
  localparam int DEF_MAX_DST_HEIGHT = 2048;
  localparam int DEF_FRAC_BITS      = 8;

  // operation codes on in_tuser
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // zero reads as one, anything above the limit reads as the limit
  function automatic int sat_cfg(input int v, input int maxv);
    int r;
    if (v == 0) r = 1;
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage

// ===== hdl/biu_ram.sv =====
// biu_ram: generic simple dual-port ram, one write port and one registered read port
// depends on biu_pkg for the default WIDTH (PIX_W)
module biu_ram
  import biu_pkg::*;
#(
  parameter int WIDTH = PIX_W,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bilinear_image_upscaler.sv =====
// bilinear_image_upscaler: frame store in four parity banks plus a pipelined bilinear resampler
// depends on biu_pkg and biu_ram
// one beat accepted per cycle while out_tready does not stall the pipe, set by the pipelined
// restoring divider, one quotient bit per stage, and by the four banks that deliver all
// neighbors in one read; rst_n (synchronous) clears valid bits and loads the register
// reset values; the frame store is not cleared
module bilinear_image_upscaler
  import biu_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
  parameter int MAX_DST_WIDTH  = DEF_MAX_DST_WIDTH,
  parameter int MAX_DST_HEIGHT = DEF_MAX_DST_HEIGHT,
  parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // x_coord, y_coord, red_in, green_in, blue_in, pad
  input  logic [0:0]            in_tuser,  // operation
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // red_out, green_out, blue_out
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int F    = FRAC_BITS;
  localparam int SWW  = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SHW  = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int DWW  = $clog2(MAX_DST_WIDTH + 1);
  localparam int DHW  = $clog2(MAX_DST_HEIGHT + 1);
  localparam int S_W  = (SWW > SHW) ? SWW : SHW;
  localparam int D_W  = (DWW > DHW) ? DWW : DHW;
  localparam int PW   = D_W + 1 + S_W;
  localparam int QW   = S_W + F;
  localparam int HW   = (MAX_SRC_WIDTH + 1) / 2;
  localparam int HH   = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int BDEP = HW * HH;
  localparam int AW   = (BDEP > 1) ? $clog2(BDEP) : 1;
  localparam int TW   = F + CH_W + 1;
  localparam int VW   = 2 * F + CH_W + 2;

  typedef struct packed {
    logic             vld;
    logic             op;
    logic             ok;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [PIX_W-1:0] pix;
  } meta_t;

  typedef struct packed {
    meta_t         m;
    logic [PW-1:0] nx;
    logic [PW-1:0] ny;
    logic          ngx;
    logic          ngy;
  } num_t;

  typedef struct packed {
    meta_t         m;
    logic [D_W:0]  rx;
    logic [D_W:0]  ry;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic          ngx;
    logic          ngy;
  } div_t;

  typedef struct packed {
    meta_t          m;
    logic [S_W-1:0] x0;
    logic [S_W-1:0] x1;
    logic [S_W-1:0] y0;
    logic [S_W-1:0] y1;
    logic [F-1:0]   fx;
    logic [F-1:0]   fy;
  } clamp_t;

  typedef struct packed {
    logic         vld;
    logic         x0p;
    logic         x1p;
    logic         y0p;
    logic         y1p;
    logic [F-1:0] fx;
    logic [F-1:0] fy;
  } rd_t;

  // configuration registers
  logic [SWW-1:0] sw_r;
  logic [SHW-1:0] sh_r;
  logic [DWW-1:0] dw_r;
  logic [DHW-1:0] dh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= SWW'(sat_cfg(SRC_W_RST, MAX_SRC_WIDTH));
      sh_r <= SHW'(sat_cfg(SRC_H_RST, MAX_SRC_HEIGHT));
      dw_r <= DWW'(sat_cfg(DST_W_RST, MAX_DST_WIDTH));
      dh_r <= DHW'(sat_cfg(DST_H_RST, MAX_DST_HEIGHT));
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_SRC_WIDTH:
          sw_r <= SWW'(sat_cfg(int'(cfg_data[SRC_W_FW-1:0]), MAX_SRC_WIDTH));
        CFG_SRC_HEIGHT:
          sh_r <= SHW'(sat_cfg(int'(cfg_data[SRC_H_FW-1:0]), MAX_SRC_HEIGHT));
        CFG_DST_WIDTH:
          dw_r <= DWW'(sat_cfg(int'(cfg_data[DST_W_FW-1:0]), MAX_DST_WIDTH));
        CFG_DST_HEIGHT:
          dh_r <= DHW'(sat_cfg(int'(cfg_data[DST_H_FW-1:0]), MAX_DST_HEIGHT));
      endcase
    end
  end

  // numerator of the half-pixel map, shifted up by one denominator when negative
  function automatic logic [PW:0] axis_num(input logic [X_W-1:0] d,
                                           input logic [S_W-1:0] s,
                                           input logic [D_W-1:0] dn);
    logic [D_W:0]  t;
    logic [PW-1:0] prod;
    logic [PW-1:0] dne;
    t    = {D_W'(d), 1'b1};
    prod = PW'(t) * PW'(s);
    dne  = PW'(dn);
    if (prod < dne) return {1'b1, prod + dne};
    else return {1'b0, prod - dne};
  endfunction

  logic   en;
  meta_t  p0_r;
  num_t   p1_r;
  div_t   dv_r   [QW];
  div_t   dv_nxt [QW];
  div_t   dv_init;
  clamp_t pc_r;
  clamp_t pc_nxt;
  rd_t    pd_r;
  logic   pb_vld_r;
  logic [TW-1:0] top_r [3];
  logic [TW-1:0] bot_r [3];
  logic [F-1:0]  pb_fy_r;
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign en         = !out_vld_r || out_tready;
  assign in_tready  = en || !p0_r.vld;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // input beat register, doubles as skid stage while the pipe is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r.vld <= 1'b0;
    end else if (in_tready) begin
      p0_r.vld <= in_tvalid;
    end
    if (in_tready) begin
      p0_r.op  <= in_tuser[0];
      p0_r.ok  <= 1'b0;
      p0_r.x   <= in_tdata[10:0];
      p0_r.y   <= in_tdata[21:11];
      p0_r.pix <= in_tdata[51:22];
    end
  end

  // range checks and numerators
  logic [PW:0] numx, numy;
  logic        ok0;
  always_comb begin
    numx = axis_num(p0_r.x, S_W'(sw_r), D_W'(dw_r));
    numy = axis_num(p0_r.y, S_W'(sh_r), D_W'(dh_r));
    if (p0_r.op == OP_REQUEST)
      ok0 = (32'(p0_r.x) < 32'(dw_r)) && (32'(p0_r.y) < 32'(dh_r));
    else
      ok0 = (32'(p0_r.x) < 32'(sw_r)) && (32'(p0_r.y) < 32'(sh_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.m.vld <= 1'b0;
    end else if (en) begin
      p1_r.m.vld <= p0_r.vld;
    end
    if (en) begin
      p1_r.m.op  <= p0_r.op;
      p1_r.m.ok  <= ok0;
      p1_r.m.x   <= p0_r.x;
      p1_r.m.y   <= p0_r.y;
      p1_r.m.pix <= p0_r.pix;
      p1_r.nx    <= numx[PW-1:0];
      p1_r.ngx   <= numx[PW];
      p1_r.ny    <= numy[PW-1:0];
      p1_r.ngy   <= numy[PW];
    end
  end

  // divider stages: one quotient bit per stage for both axes
  logic [D_W:0] denx, deny;
  assign denx = {D_W'(dw_r), 1'b0};
  assign deny = {D_W'(dh_r), 1'b0};

  always_comb begin
    dv_init.m   = p1_r.m;
    dv_init.rx  = p1_r.nx[PW-1:S_W];
    dv_init.ry  = p1_r.ny[PW-1:S_W];
    dv_init.qx  = {p1_r.nx[S_W-1:0], {F{1'b0}}};
    dv_init.qy  = {p1_r.ny[S_W-1:0], {F{1'b0}}};
    dv_init.ngx = p1_r.ngx;
    dv_init.ngy = p1_r.ngy;
  end

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      div_t         src;
      logic [D_W+1:0] tx;
      logic [D_W+1:0] ty;
      src = (k == 0) ? dv_init : dv_r[(k == 0) ? 0 : k - 1];
      tx  = {src.rx, src.qx[QW-1]};
      ty  = {src.ry, src.qy[QW-1]};
      dv_nxt[k] = src;
      if (tx >= {1'b0, denx}) begin
        dv_nxt[k].rx = (D_W+1)'(tx - {1'b0, denx});
        dv_nxt[k].qx = {src.qx[QW-2:0], 1'b1};
      end else begin
        dv_nxt[k].rx = tx[D_W:0];
        dv_nxt[k].qx = {src.qx[QW-2:0], 1'b0};
      end
      if (ty >= {1'b0, deny}) begin
        dv_nxt[k].ry = (D_W+1)'(ty - {1'b0, deny});
        dv_nxt[k].qy = {src.qy[QW-2:0], 1'b1};
      end else begin
        dv_nxt[k].ry = ty[D_W:0];
        dv_nxt[k].qy = {src.qy[QW-2:0], 1'b0};
      end
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[g].m.vld <= 1'b0;
      end else if (en) begin
        dv_r[g].m.vld <= dv_nxt[g].m.vld;
      end
      if (en) begin
        dv_r[g].m.op  <= dv_nxt[g].m.op;
        dv_r[g].m.ok  <= dv_nxt[g].m.ok;
        dv_r[g].m.x   <= dv_nxt[g].m.x;
        dv_r[g].m.y   <= dv_nxt[g].m.y;
        dv_r[g].m.pix <= dv_nxt[g].m.pix;
        dv_r[g].rx    <= dv_nxt[g].rx;
        dv_r[g].ry    <= dv_nxt[g].ry;
        dv_r[g].qx    <= dv_nxt[g].qx;
        dv_r[g].qy    <= dv_nxt[g].qy;
        dv_r[g].ngx   <= dv_nxt[g].ngx;
        dv_r[g].ngy   <= dv_nxt[g].ngy;
      end
    end
  end

  // floor index, clamp of both neighbors, fractional weights
  logic [S_W-1:0] ipx, ipy, smx, smy;
  always_comb begin
    ipx = dv_r[QW-1].qx[QW-1:F];
    ipy = dv_r[QW-1].qy[QW-1:F];
    smx = S_W'(sw_r) - S_W'(1);
    smy = S_W'(sh_r) - S_W'(1);
    pc_nxt.m  = dv_r[QW-1].m;
    pc_nxt.fx = dv_r[QW-1].qx[F-1:0];
    pc_nxt.fy = dv_r[QW-1].qy[F-1:0];
    if (dv_r[QW-1].ngx) begin
      pc_nxt.x0 = '0;
      pc_nxt.x1 = '0;
    end else begin
      pc_nxt.x0 = (ipx > smx) ? smx : ipx;
      pc_nxt.x1 = (ipx >= smx) ? smx : ipx + S_W'(1);
    end
    if (dv_r[QW-1].ngy) begin
      pc_nxt.y0 = '0;
      pc_nxt.y1 = '0;
    end else begin
      pc_nxt.y0 = (ipy > smy) ? smy : ipy;
      pc_nxt.y1 = (ipy >= smy) ? smy : ipy + S_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r.m.vld <= 1'b0;
    end else if (en) begin
      pc_r.m.vld <= pc_nxt.m.vld;
    end
    if (en) begin
      pc_r.m.op  <= pc_nxt.m.op;
      pc_r.m.ok  <= pc_nxt.m.ok;
      pc_r.m.x   <= pc_nxt.m.x;
      pc_r.m.y   <= pc_nxt.m.y;
      pc_r.m.pix <= pc_nxt.m.pix;
      pc_r.x0    <= pc_nxt.x0;
      pc_r.x1    <= pc_nxt.x1;
      pc_r.y0    <= pc_nxt.y0;
      pc_r.y1    <= pc_nxt.y1;
      pc_r.fx    <= pc_nxt.fx;
      pc_r.fy    <= pc_nxt.fy;
    end
  end

  // bank access: bank index is {row parity, column parity}
  logic [S_W-1:0] colb [2];
  logic [S_W-1:0] rowb [2];
  logic [S_W-1:0] wx, wy;
  logic           wr_go;
  logic [PIX_W-1:0] bank_q [4];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      colb[p] = (pc_r.x0[0] == p[0]) ? (pc_r.x0 >> 1) : (pc_r.x1 >> 1);
      rowb[p] = (pc_r.y0[0] == p[0]) ? (pc_r.y0 >> 1) : (pc_r.y1 >> 1);
    end
    wx    = S_W'(pc_r.m.x);
    wy    = S_W'(pc_r.m.y);
    wr_go = en && pc_r.m.vld && (pc_r.m.op == OP_WRITE) && pc_r.m.ok;
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [AW-1:0] ra, wa;
    logic          bwe;
    assign ra  = AW'(rowb[b / 2]) * AW'(HW) + AW'(colb[b % 2]);
    assign wa  = AW'(wy >> 1) * AW'(HW) + AW'(wx >> 1);
    assign bwe = wr_go && (wx[0] == ((b % 2) != 0)) && (wy[0] == ((b / 2) != 0));
    biu_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BDEP)
    ) u_bank (
      .clk   (clk),
      .we    (bwe),
      .waddr (wa),
      .wdata (pc_r.m.pix),
      .re    (en),
      .raddr (ra),
      .rdata (bank_q[b])
    );
  end

  // read stage bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_r.vld <= 1'b0;
    end else if (en) begin
      pd_r.vld <= pc_r.m.vld && (pc_r.m.op == OP_REQUEST) && pc_r.m.ok;
    end
    if (en) begin
      pd_r.x0p <= pc_r.x0[0];
      pd_r.x1p <= pc_r.x1[0];
      pd_r.y0p <= pc_r.y0[0];
      pd_r.y1p <= pc_r.y1[0];
      pd_r.fx  <= pc_r.fx;
      pd_r.fy  <= pc_r.fy;
    end
  end

  // horizontal blend of the top and bottom neighbor pairs
  logic [PIX_W-1:0] c00, c10, c01, c11;
  logic [F:0]       wx0;
  logic [TW-1:0]    top_nxt [3];
  logic [TW-1:0]    bot_nxt [3];
  always_comb begin
    c00 = bank_q[{pd_r.y0p, pd_r.x0p}];
    c10 = bank_q[{pd_r.y0p, pd_r.x1p}];
    c01 = bank_q[{pd_r.y1p, pd_r.x0p}];
    c11 = bank_q[{pd_r.y1p, pd_r.x1p}];
    wx0 = {1'b1, F'(0)} - {1'b0, pd_r.fx};
    for (int k = 0; k < 3; k++) begin
      top_nxt[k] = TW'(wx0) * TW'(c00[k*CH_W +: CH_W])
                 + TW'(pd_r.fx) * TW'(c10[k*CH_W +: CH_W]);
      bot_nxt[k] = TW'(wx0) * TW'(c01[k*CH_W +: CH_W])
                 + TW'(pd_r.fx) * TW'(c11[k*CH_W +: CH_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_vld_r <= 1'b0;
    end else if (en) begin
      pb_vld_r <= pd_r.vld;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        top_r[k] <= top_nxt[k];
        bot_r[k] <= bot_nxt[k];
      end
      pb_fy_r <= pd_r.fy;
    end
  end

  // vertical blend, truncate, saturate
  logic [F:0]            wy0;
  logic [VW-1:0]         acc [3];
  logic [OUT_DATA_W-1:0] res_nxt;
  always_comb begin
    wy0 = {1'b1, F'(0)} - {1'b0, pb_fy_r};
    for (int k = 0; k < 3; k++) begin
      acc[k] = VW'(wy0) * VW'(top_r[k]) + VW'(pb_fy_r) * VW'(bot_r[k]);
      res_nxt[k*OUT_W +: OUT_W] = (|acc[k][VW-1:2*F+OUT_W]) ? {OUT_W{1'b1}}
                                                             : acc[k][2*F +: OUT_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= pb_vld_r;
    end
    if (en) begin
      out_data_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  // an empty skid stage always takes a beat
  assert property (@(posedge clk) disable iff (!rst_n) !p0_r.vld |-> in_tready)
    else $error("input refused with empty skid stage");
  // a stalled pipe keeps its items
  assert property (@(posedge clk) disable iff (!rst_n) !en && p1_r.m.vld |=> p1_r.m.vld)
    else $error("item lost during stall");
  // clamped neighbors lie inside the source frame
  assert property (@(posedge clk) disable iff (!rst_n)
      pc_r.m.vld && pc_r.m.op == OP_REQUEST && pc_r.m.ok
      |-> 32'(pc_r.x1) < 32'(sw_r) && 32'(pc_r.y1) < 32'(sh_r))
    else $error("neighbor outside source frame");
  // neighbors are equal or adjacent
  assert property (@(posedge clk) disable iff (!rst_n)
      pc_r.m.vld && pc_r.m.op == OP_REQUEST && pc_r.m.ok
      |-> (pc_r.x1 == pc_r.x0 || pc_r.x1 == pc_r.x0 + S_W'(1)) &&
          (pc_r.y1 == pc_r.y0 || pc_r.y1 == pc_r.y0 + S_W'(1)))
    else $error("neighbors not adjacent");
`endif

endmodule

// ===== test/bilinear_image_upscaler_tb.sv =====
// bilinear_image_upscaler_tb: self-checking testbench for the bilinear upscaler
// predicts each destination pixel from its own copy of the source frame and registers
// depends on biu_pkg and the bilinear_image_upscaler rtl
module bilinear_image_upscaler_tb;
  import biu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB         = DEF_FRAC_BITS;
  localparam int CYCLE_CAP  = 600000;
  localparam int DRAIN_WAIT = 40;

  typedef struct {
    logic        op;
    logic [10:0] x;
    logic [10:0] y;
    logic [9:0]  r;
    logic [9:0]  g;
    logic [9:0]  b;
  } pix_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;  // x_coord, y_coord, red_in, green_in, blue_in, pad
  logic [0:0]            in_tuser = '0;  // operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // red_out, green_out, blue_out
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bilinear_image_upscaler u_top (.*);

  // clock
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // predictor state
  int               m_sw = SRC_W_RST, m_sh = SRC_H_RST, m_dw = DST_W_RST, m_dh = DST_H_RST;
  logic [29:0]      frame_mirror [int];
  bit               planned_pix [int];
  pix_beat_t        beat_q [$];
  logic [23:0]      pixel_exp_q [$];
  bit               beat_taken = 1'b0;
  int               errors = 0, cycles = 0, n_wr = 0, n_req = 0, n_pix = 0;

  function automatic int sat_reg(input int v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int clamp_idx(input int v, input int n);
    if (v < 0) return 0;
    if (v > n - 1) return n - 1;
    return v;
  endfunction

  // half-pixel center mapping: floor index and fractional weight
  function automatic void map_axis(input int d, input int s, input int dn,
                                   output int idx, output int frac);
    longint num, den, rem;
    num = longint'(2 * d + 1) * s - dn;
    den = 2 * longint'(dn);
    if (num < 0) begin
      idx = -1;
      rem = num + den;
    end else begin
      idx = int'(num / den);
      rem = num % den;
    end
    frac = int'((rem << FB) / den);
  endfunction

  // the four neighbor addresses and weights of a destination pixel
  function automatic void neighbors(input int dx, input int dy, output int a[4],
                                    output int fx, output int fy);
    int ix, iy, x0, x1, y0, y1;
    map_axis(dx, m_sw, m_dw, ix, fx);
    map_axis(dy, m_sh, m_dh, iy, fy);
    x0 = clamp_idx(ix, m_sw);
    x1 = clamp_idx(ix + 1, m_sw);
    y0 = clamp_idx(iy, m_sh);
    y1 = clamp_idx(iy + 1, m_sh);
    a[0] = y0 * DEF_MAX_SRC_WIDTH + x0;
    a[1] = y0 * DEF_MAX_SRC_WIDTH + x1;
    a[2] = y1 * DEF_MAX_SRC_WIDTH + x0;
    a[3] = y1 * DEF_MAX_SRC_WIDTH + x1;
  endfunction

  // apply one accepted beat to the mirror, queue the pixel it yields
  function automatic void upscale_step(input pix_beat_t t);
    int a[4], fx, fy;
    longint c[4], top, bot, v;
    logic [23:0] px;
    if (t.op == OP_WRITE) begin
      n_wr++;
      if (t.x < m_sw && t.y < m_sh)
        frame_mirror[t.y * DEF_MAX_SRC_WIDTH + t.x] = {t.b, t.g, t.r};
      return;
    end
    n_req++;
    if (t.x >= m_dw || t.y >= m_dh) return;
    neighbors(t.x, t.y, a, fx, fy);
    for (int k = 0; k < 3; k++) begin
      for (int n = 0; n < 4; n++)
        c[n] = frame_mirror.exists(a[n]) ? longint'((frame_mirror[a[n]] >> (10 * k)) & 10'h3ff)
                                         : 0;
      top = ((1 << FB) - fx) * c[0] + fx * c[1];
      bot = ((1 << FB) - fx) * c[2] + fx * c[3];
      v = (((1 << FB) - fy) * top + fy * bot) >> (2 * FB);
      px[8*k +: 8] = (v > 255) ? 8'd255 : v[7:0];
    end
    pixel_exp_q.push_back(px);
  endfunction

  // cycle counter and cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t timeout with %0d pixels outstanding", $time, pixel_exp_q.size());
      $display("bilinear_image_upscaler_tb: errors");
      $finish;
    end
  end

  // input beat acceptance feeds the predictor
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      upscale_step(beat_q.pop_front());
      beat_taken = 1'b1;
    end
  end

  // driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    pix_beat_t t;
    if (in_tvalid && !beat_taken) begin
      // beat still pending, hold it
    end else if (gap_left > 0 || beat_q.size() == 0 || !rst_n) begin
      if (gap_left > 0) gap_left--;
      in_tvalid <= 1'b0;
    end else begin
      t = beat_q[0];
      in_tvalid <= 1'b1;
      in_tuser  <= t.op;
      in_tdata  <= {4'b0, t.b, t.g, t.r, t.y, t.x};
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
    beat_taken = 1'b0;
  end

  // receiver stall pattern: randomly chosen modes of always ready, half ready or mostly stalled
  int rdy_mode = 0;
  always @(negedge clk) begin
    if (cycles % 64 == 0) rdy_mode = $urandom_range(0, 2);
    case (rdy_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    logic [23:0] want;
    if (out_tvalid && out_tready) begin
      if (pixel_exp_q.size() == 0) begin
        errors++;
        $display("%0t unexpected pixel: got %h", $time, out_tdata);
      end else begin
        want = pixel_exp_q.pop_front();
        n_pix++;
        for (int k = 0; k < 3; k++)
          if (out_tdata[8*k +: 8] !== want[8*k +: 8]) begin
            errors++;
            $display("%0t channel %0d mismatch: expected %0d got %0d", $time, k,
                     want[8*k +: 8], out_tdata[8*k +: 8]);
          end
      end
    end
  end

  task automatic push_beat(input logic op, input int x, input int y, input int r,
                           input int g, input int b);
    pix_beat_t t;
    t.op = op; t.x = 11'(x); t.y = 11'(y); t.r = 10'(r); t.g = 10'(g); t.b = 10'(b);
    if (op == OP_WRITE && x < m_sw && y < m_sh)
      planned_pix[y * DEF_MAX_SRC_WIDTH + x] = 1'b1;
    beat_q.push_back(t);
  endtask

  function automatic int rand_chan();
    return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 255);
  endfunction

  // request a pixel, first writing any neighbor that was never stored
  task automatic add_request(input int x, input int y);
    int a[4], fx, fy;
    if (x < m_dw && y < m_dh) begin
      neighbors(x, y, a, fx, fy);
      for (int n = 0; n < 4; n++)
        if (!planned_pix.exists(a[n]))
          push_beat(OP_WRITE, a[n] % DEF_MAX_SRC_WIDTH, a[n] / DEF_MAX_SRC_WIDTH,
                    rand_chan(), rand_chan(), rand_chan());
    end
    push_beat(OP_REQUEST, x, y, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023));
  endtask

  // pause the sender until the block has drained
  task automatic wait_idle();
    while (beat_q.size() != 0 || in_tvalid || pixel_exp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // program all four registers while idle
  task automatic set_frame(input int sw, input int sh, input int dw, input int dh);
    int v[4];
    v = '{sw, sh, dw, dh};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= cfg_idx_t'(i);
      cfg_data <= CFG_DATA_W'(v[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    m_sw = sat_reg(sw & 12'h7ff, DEF_MAX_SRC_WIDTH);
    m_sh = sat_reg(sw >= 0 ? (sh & 12'h3ff) : 0, DEF_MAX_SRC_HEIGHT);
    m_dw = sat_reg(dw & 12'hfff, DEF_MAX_DST_WIDTH);
    m_dh = sat_reg(dh & 12'hfff, DEF_MAX_DST_HEIGHT);
  endtask

  // random traffic: mostly in-frame requests and writes, some noise
  task automatic run_traffic(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50)
        add_request($urandom_range(0, m_dw - 1), $urandom_range(0, m_dh - 1));
      else if (sel < 58)
        add_request($urandom_range(0, 2047), $urandom_range(0, 2047));
      else if (sel < 90)
        push_beat(OP_WRITE, $urandom_range(0, m_sw - 1), $urandom_range(0, m_sh - 1),
                  rand_chan(), rand_chan(), rand_chan());
      else
        push_beat(OP_WRITE, $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
    end
  endtask

  initial begin
    int sw, sh;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset geometry, corners and extremes
    push_beat(OP_WRITE, 0, 0, 1023, 1023, 1023);
    push_beat(OP_WRITE, 1023, 511, 0, 1023, 341);
    push_beat(OP_WRITE, 2047, 2047, 1023, 1023, 1023);
    add_request(0, 0);
    add_request(2047, 2047);
    add_request(1024, 511);

    // directed: small upscale with out-of-frame items
    set_frame(4, 4, 8, 8);
    push_beat(OP_WRITE, 4, 0, 5, 5, 5);
    push_beat(OP_WRITE, 0, 4, 5, 5, 5);
    add_request(8, 0);
    add_request(0, 8);
    add_request(0, 0);
    add_request(7, 7);
    add_request(3, 4);
    push_beat(OP_WRITE, 3, 3, 0, 0, 0);
    add_request(7, 7);

    // directed: zero registers act as one, oversized act as the limit
    set_frame(0, 0, 0, 0);
    add_request(0, 0);
    add_request(1, 0);
    set_frame(4095, 4095, 4095, 4095);
    add_request(2047, 0);
    add_request(0, 2047);

    // random phases over several geometries, extremes included
    set_frame(1024, 512, 2048, 2048);
    run_traffic(70);
    set_frame(1, 1, 2048, 2048);
    run_traffic(60);
    set_frame(1024, 512, 1, 1);
    run_traffic(60);
    for (int p = 0; p < 9; p++) begin
      sw = $urandom_range(1, 20);
      sh = $urandom_range(1, 20);
      set_frame(sw, sh, $urandom_range(1, 64), $urandom_range(1, 64));
      run_traffic(60);
    end
    set_frame(2, 2, 1, 2048);
    run_traffic(60);

    wait_idle();
    $display("covered %0d writes and %0d requests across 17 register settings", n_wr, n_req);
    $display("%0d interpolated pixels checked, %0d mismatches", n_pix, errors);
    if (errors == 0) begin
      $display("bilinear_image_upscaler_tb: clean");
    end else begin
      $display("bilinear_image_upscaler_tb: errors");
    end
    $finish;
  end

endmodule
